>>> rtl/core/xild_pkg.sv
package xild_pkg;

  // Window geometry
  localparam int unsigned WINDOW_BYTES = 15;
  localparam int unsigned BYTE_CNT     = 15;
  localparam int unsigned WIN_LIMIT    = (WINDOW_BYTES < 15) ? WINDOW_BYTES : 15;
  localparam int unsigned POS_W        = 4;
  localparam int unsigned LEN_W        = 5;
  localparam int unsigned EXTRA_W      = 4;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_WINDOW  = 2'd2;

  typedef struct packed {
    logic [55:0] bytes_high;
    logic [63:0] bytes_low;
  } in_word_t;

  typedef struct packed {
    logic [3:0] insn_length;
    logic [1:0] status;
  } out_word_t;

  // Stage 1: bytes with per-byte prefix flags
  typedef struct packed {
    logic                    valid;
    logic [BYTE_CNT-1:0]     pfx;
    logic [BYTE_CNT-1:0]     rex;
    logic [BYTE_CNT*8-1:0]   bytes;
  } s1_t;

  // Stage 2: opcode position and the bytes that follow it
  typedef struct packed {
    logic             valid;
    logic             no_op;
    logic             rex;
    logic [POS_W-1:0] pos;
    logic [7:0]       op;
    logic [7:0]       b1;
    logic [7:0]       b2;
    logic [7:0]       b3;
  } s2_t;

  // Stage 3: length split into base and tail sizes
  typedef struct packed {
    logic               valid;
    logic               win_err;
    logic               unknown;
    logic [LEN_W-1:0]   base;
    logic [EXTRA_W-1:0] extra;
  } s3_t;

endpackage

>>> rtl/core/xild_classify.sv
module xild_classify (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             long_mode,
  input  xild_pkg::in_word_t in_data,
  output xild_pkg::s1_t    s1
);

  xild_pkg::s1_t s1_r;
  xild_pkg::s1_t s1_nxt;

  always_comb begin
    logic [7:0] b;
    s1_nxt       = '0;
    s1_nxt.valid = in_valid;
    s1_nxt.bytes = {in_data.bytes_high, in_data.bytes_low};
    for (int i = 0; i < xild_pkg::BYTE_CNT; i++) begin
      b = s1_nxt.bytes[i*8 +: 8];
      case (b) inside
        8'h66, 8'h67, 8'hF2, 8'hF3, 8'h2E, 8'h36, 8'h3E, 8'h26, 8'h64, 8'h65:
          s1_nxt.pfx[i] = (i < xild_pkg::WIN_LIMIT);
        [8'h40:8'h4F]: begin
          s1_nxt.pfx[i] = long_mode && (i < xild_pkg::WIN_LIMIT);
          s1_nxt.rex[i] = long_mode && (i < xild_pkg::WIN_LIMIT);
        end
        default: s1_nxt.pfx[i] = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else begin
      s1_r.valid <= s1_nxt.valid;
    end
    s1_r.pfx   <= s1_nxt.pfx;
    s1_r.rex   <= s1_nxt.rex;
    s1_r.bytes <= s1_nxt.bytes;
  end

  assign s1 = s1_r;

endmodule

>>> rtl/core/xild_locate.sv
module xild_locate (
  input  logic          clk,
  input  logic          rst_n,
  input  xild_pkg::s1_t s1,
  output xild_pkg::s2_t s2
);

  localparam int unsigned EXT_BITS = (xild_pkg::BYTE_CNT + 3) * 8;

  xild_pkg::s2_t s2_r;
  xild_pkg::s2_t s2_nxt;

  logic [EXT_BITS-1:0] ext;

  always_comb begin
    logic found;
    found  = 1'b0;
    s2_nxt = '0;
    s2_nxt.valid = s1.valid;
    // First byte that is not a prefix is the opcode; REX counts only before it
    for (int i = 0; i < xild_pkg::BYTE_CNT; i++) begin
      if (!found) begin
        if (s1.pfx[i]) begin
          s2_nxt.rex = s2_nxt.rex | s1.rex[i];
        end else begin
          found      = 1'b1;
          s2_nxt.pos = xild_pkg::POS_W'(i);
        end
      end
    end
    s2_nxt.no_op = !found;
    // Bytes past the window read as zero
    ext = {24'd0, s1.bytes} >> {s2_nxt.pos, 3'b000};
    s2_nxt.op = ext[7:0];
    s2_nxt.b1 = ext[15:8];
    s2_nxt.b2 = ext[23:16];
    s2_nxt.b3 = ext[31:24];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else begin
      s2_r.valid <= s2_nxt.valid;
    end
    s2_r.no_op <= s2_nxt.no_op;
    s2_r.rex   <= s2_nxt.rex;
    s2_r.pos   <= s2_nxt.pos;
    s2_r.op    <= s2_nxt.op;
    s2_r.b1    <= s2_nxt.b1;
    s2_r.b2    <= s2_nxt.b2;
    s2_r.b3    <= s2_nxt.b3;
  end

  assign s2 = s2_r;

endmodule

>>> rtl/core/xild_decode.sv
module xild_decode (
  input  logic          clk,
  input  logic          rst_n,
  input  xild_pkg::s2_t s2,
  output xild_pkg::s3_t s3
);

  xild_pkg::s3_t s3_r;
  xild_pkg::s3_t s3_nxt;

  logic                        use_modrm;
  logic                        at2;
  logic [3:0]                  imm;
  logic [7:0]                  m;
  logic [7:0]                  sib;
  logic [2:0]                  disp;
  logic                        has_sib;
  logic [2:0]                  mrm_bytes;
  logic [xild_pkg::LEN_W-1:0]  next_pos;

  always_comb begin
    use_modrm = 1'b0;
    at2       = 1'b0;
    imm       = 4'd0;
    s3_nxt    = '0;
    s3_nxt.valid = s2.valid;
    next_pos  = {1'b0, s2.pos} + xild_pkg::LEN_W'(1);

    if (s2.no_op) begin
      s3_nxt.win_err = 1'b1;
    end else begin
      unique case (s2.op) inside
        8'h90, 8'hC3, 8'hCB, 8'hCC, 8'hC9, [8'h50:8'h5F]: imm = 4'd0;
        8'h6A, 8'hCD, [8'hB0:8'hB7], 8'hEB, [8'h70:8'h7F]: imm = 4'd1;
        8'h68, 8'hE9, 8'hE8: imm = 4'd4;
        [8'hB8:8'hBF]: imm = s2.rex ? 4'd8 : 4'd4;
        8'hC2: imm = 4'd2;
        8'h83, 8'h80, 8'hC6, 8'hF6: begin
          use_modrm = 1'b1;
          imm       = 4'd1;
        end
        8'h81, 8'hC7: begin
          use_modrm = 1'b1;
          imm       = 4'd4;
        end
        8'h89, 8'h8B, 8'h8D, 8'h85, 8'h87, 8'h01, 8'h03, 8'h09, 8'h0B, 8'h21, 8'h23,
        8'h29, 8'h2B, 8'h31, 8'h33, 8'h39, 8'h3B, 8'h63, 8'hFF, 8'hFE, 8'hF7, 8'hD1,
        8'hD3: use_modrm = 1'b1;
        8'h0F: begin
          at2 = 1'b1;
          if (next_pos >= xild_pkg::LEN_W'(xild_pkg::WIN_LIMIT)) begin
            s3_nxt.win_err = 1'b1;
          end else begin
            unique case (s2.b1) inside
              [8'h80:8'h8F]: imm = 4'd4;
              [8'h40:8'h4F], 8'hB6, 8'hB7, 8'hBE, 8'hBF, 8'hAF, 8'h10, 8'h11, 8'h28,
              8'h29, 8'h2E, 8'h2F, 8'h51, 8'h54, 8'h57, 8'h58, 8'h59, 8'h5C,
              8'h1F: use_modrm = 1'b1;
              default: s3_nxt.unknown = 1'b1;
            endcase
          end
        end
        default: s3_nxt.unknown = 1'b1;
      endcase
    end

    // ModR/M, optional SIB and displacement
    m       = at2 ? s2.b2 : s2.b1;
    sib     = at2 ? s2.b3 : s2.b2;
    has_sib = (m[7:6] != 2'd3) && (m[2:0] == 3'd4);
    case (m[7:6])
      2'd0:    disp = ((m[2:0] == 3'd5) || (has_sib && sib[2:0] == 3'd5)) ? 3'd4 : 3'd0;
      2'd1:    disp = 3'd1;
      2'd2:    disp = 3'd4;
      default: disp = 3'd0;
    endcase
    mrm_bytes = 3'd1 + {2'b00, has_sib} + disp;

    s3_nxt.base  = next_pos + {{(xild_pkg::LEN_W-1){1'b0}}, at2};
    s3_nxt.extra = (use_modrm ? {1'b0, mrm_bytes} : 4'd0) + imm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r.valid <= 1'b0;
    end else begin
      s3_r.valid <= s3_nxt.valid;
    end
    s3_r.win_err <= s3_nxt.win_err;
    s3_r.unknown <= s3_nxt.unknown;
    s3_r.base    <= s3_nxt.base;
    s3_r.extra   <= s3_nxt.extra;
  end

  assign s3 = s3_r;

endmodule

>>> rtl/core/x86_instruction_length_decoder.sv
// Channel   Ports                               Handshake
// input     start, busy, in_data                word taken when start && !busy
// result    out_valid, out_data                 word valid for one cycle, no hold-off
// config    cfg_wr_en, cfg_wr_data              long_mode written when cfg_wr_en
//
// One word enters every cycle; busy is always low.
// Stages: classify bytes, locate opcode, decode, sum and check; each ends in a register.
// The result appears after the word has passed every stage register, for one cycle.
// Synchronous active-low reset clears the stage valid bits and sets long_mode.
// The receiver cannot stall, so the pipeline never holds.
module x86_instruction_length_decoder (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  xild_pkg::in_word_t    in_data,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data,
  output logic                  out_valid,
  output xild_pkg::out_word_t   out_data
);

  logic                       long_mode_r;
  logic                       out_valid_r;
  xild_pkg::out_word_t        out_data_r;
  xild_pkg::out_word_t        out_data_nxt;
  logic [xild_pkg::LEN_W-1:0] len_sum;

  xild_pkg::s1_t s1;
  xild_pkg::s2_t s2;
  xild_pkg::s3_t s3;

  // Pipeline never stalls: accept a word every cycle
  assign busy = 1'b0;

  // Mode register; the user must write it only while no word is in flight; the block has no check for this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_mode_r <= 1'b1;
    end else if (cfg_wr_en) begin
      long_mode_r <= cfg_wr_data;
    end
  end

  // Stage 1: flag legacy and REX prefixes per byte
  xild_classify u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .long_mode (long_mode_r),
    .in_data   (in_data),
    .s1        (s1)
  );

  // Stage 2: find the opcode after the prefix run, pull following bytes
  xild_locate u_locate (
    .clk   (clk),
    .rst_n (rst_n),
    .s1    (s1),
    .s2    (s2)
  );

  // Stage 3: classify opcode, size ModR/M, SIB, displacement and immediate
  xild_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .s2    (s2),
    .s3    (s3)
  );

  // Stage 4: add up the length, check it against the window, drop it on error
  always_comb begin
    len_sum = s3.base + {1'b0, s3.extra};
    out_data_nxt = '0;
    if (s3.win_err) begin
      out_data_nxt.status = xild_pkg::ST_WINDOW;
    end else if (s3.unknown) begin
      out_data_nxt.status = xild_pkg::ST_UNKNOWN;
    end else if (len_sum > xild_pkg::LEN_W'(xild_pkg::WIN_LIMIT)) begin
      out_data_nxt.status = xild_pkg::ST_WINDOW;
    end else begin
      out_data_nxt.status      = xild_pkg::ST_OK;
      out_data_nxt.insn_length = len_sum[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s3.valid;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##4 out_valid)
    else $error("accepted word did not produce a result four cycles later");

  a_len_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != xild_pkg::ST_OK |-> out_data.insn_length == 4'd0)
    else $error("nonzero length reported with error status");

  a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == xild_pkg::ST_OK |-> out_data.insn_length != 4'd0)
    else $error("zero length reported with ok status");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status == xild_pkg::ST_OK ||
                  out_data.status == xild_pkg::ST_UNKNOWN ||
                  out_data.status == xild_pkg::ST_WINDOW)
    else $error("undefined status code");
`endif

endmodule

>>> dv/tb_x86_instruction_length_decoder.sv
`timescale 1ns / 1ps

localparam int unsigned LATENCY = 4;

// Prefix bytes
localparam logic [7:0] PFX_OPSIZE   = 8'h66;
localparam logic [7:0] PFX_ADDRSIZE = 8'h67;
localparam logic [7:0] PFX_REP      = 8'hF3;
localparam logic [7:0] REX_LO       = 8'h40;
localparam logic [7:0] REX_HI       = 8'h4F;
localparam logic [7:0] REX_W        = 8'h48;

// One-byte opcodes and opcode ranges
localparam logic [7:0] OP_UNLISTED    = 8'h00;
localparam logic [7:0] OP_NOP         = 8'h90;
localparam logic [7:0] OP_MOV_STORE   = 8'h89;
localparam logic [7:0] OP_MOV_LOAD    = 8'h8B;
localparam logic [7:0] OP_GRP1_IMM8   = 8'h83;
localparam logic [7:0] OP_GRP1_IMM32  = 8'h81;
localparam logic [7:0] OP_MOV_IMM32   = 8'hC7;
localparam logic [7:0] OP_RET_IMM16   = 8'hC2;
localparam logic [7:0] OP_INT         = 8'hCD;
localparam logic [7:0] OP_CALL        = 8'hE8;
localparam logic [7:0] OP_ESC         = 8'h0F;
localparam logic [7:0] OP_PUSH_LO     = 8'h50;
localparam logic [7:0] OP_POP_HI      = 8'h5F;
localparam logic [7:0] OP_JCC8_LO     = 8'h70;
localparam logic [7:0] OP_JCC8_HI     = 8'h7F;
localparam logic [7:0] OP_MOV_R8_LO   = 8'hB0;
localparam logic [7:0] OP_MOV_R8_HI   = 8'hB7;
localparam logic [7:0] OP_MOV_R_LO    = 8'hB8;
localparam logic [7:0] OP_MOV_R_HI    = 8'hBF;

// Second bytes after the escape
localparam logic [7:0] OP2_JCC_LO  = 8'h80;
localparam logic [7:0] OP2_JCC_HI  = 8'h8F;
localparam logic [7:0] OP2_CMOV_LO = 8'h40;
localparam logic [7:0] OP2_CMOV_HI = 8'h4F;
localparam logic [7:0] OP2_CMOVL   = 8'h4C;
localparam logic [7:0] OP2_MOVZX   = 8'hB6;
localparam logic [7:0] OP2_UD2     = 8'h0B;

// ModR/M fields
localparam logic [1:0] MOD_INDIRECT = 2'd0;
localparam logic [1:0] MOD_DISP8    = 2'd1;
localparam logic [1:0] MOD_DISP32   = 2'd2;
localparam logic [1:0] MOD_REG      = 2'd3;
localparam logic [2:0] RM_SIB       = 3'd4;
localparam logic [2:0] RM_DISP32    = 3'd5;
localparam logic [2:0] SIB_NO_BASE  = 3'd5;

// Byte lists, first entry in the top byte
localparam logic [10*8-1:0] LEGACY_PREFIXES =
  {8'h66, 8'h67, 8'hF2, 8'hF3, 8'h2E, 8'h36, 8'h3E, 8'h26, 8'h64, 8'h65};
localparam logic [5*8-1:0] SINGLE_OPS      = {8'h90, 8'hC3, 8'hCB, 8'hCC, 8'hC9};
localparam logic [3*8-1:0] IMM8_OPS        = {8'h6A, 8'hCD, 8'hEB};
localparam logic [3*8-1:0] IMM32_OPS       = {8'h68, 8'hE8, 8'hE9};
localparam logic [4*8-1:0] MODRM_IMM8_OPS  = {8'h83, 8'h80, 8'hC6, 8'hF6};
localparam logic [2*8-1:0] MODRM_IMM32_OPS = {8'h81, 8'hC7};
localparam logic [23*8-1:0] MODRM_ONLY_OPS =
  {8'h89, 8'h8B, 8'h8D, 8'h85, 8'h87, 8'h01, 8'h03, 8'h09, 8'h0B, 8'h21, 8'h23,
   8'h29, 8'h2B, 8'h31, 8'h33, 8'h39, 8'h3B, 8'h63, 8'hFF, 8'hFE, 8'hF7, 8'hD1,
   8'hD3};
localparam logic [18*8-1:0] TWO_BYTE_MODRM_OPS =
  {8'hB6, 8'hB7, 8'hBE, 8'hBF, 8'hAF, 8'h10, 8'h11, 8'h28, 8'h29, 8'h2E, 8'h2F,
   8'h51, 8'h54, 8'h57, 8'h58, 8'h59, 8'h5C, 8'h1F};

function automatic bit op_in(logic [7:0] b, logic [183:0] list, int n);
  bit hit;
  int i;
  hit = 1'b0;
  for (i = 0; i < n; i++)
    if (list[i*8 +: 8] == b) hit = 1'b1;
  return hit;
endfunction

class length_scoreboard;
  bit long_mode = 1'b1;
  int errors;
  xild_pkg::out_word_t pending_lengths[$];
  logic [7:0] win [0:31];

  // Length of an instruction whose ModR/M byte sits at pos
  function int unsigned modrm_span(int unsigned pos, int unsigned imm);
    logic [7:0] m;
    int unsigned len, disp;
    m = win[pos];
    len = pos + 1;
    disp = 0;
    if (m[7:6] != MOD_REG) begin
      if (m[2:0] == RM_SIB) begin
        if (m[7:6] == MOD_INDIRECT && win[len][2:0] == SIB_NO_BASE) disp = 4;
        len++;
      end
      if (m[7:6] == MOD_INDIRECT && m[2:0] == RM_DISP32) disp = 4;
      else if (m[7:6] == MOD_DISP8) disp = 1;
      else if (m[7:6] == MOD_DISP32) disp = 4;
    end
    return len + disp + imm;
  endfunction

  function xild_pkg::out_word_t predict_length(xild_pkg::in_word_t w);
    int unsigned p, len, i;
    logic [7:0] op, op2, b;
    logic [1:0] status;
    bit rex, win_err, scanning;
    xild_pkg::out_word_t res;
    p = 0;
    len = 0;
    status = xild_pkg::ST_OK;
    rex = 1'b0;
    win_err = 1'b0;
    scanning = 1'b1;
    for (i = 0; i < 32; i++) win[i] = 8'h00;
    for (i = 0; i < 8; i++) win[i] = w.bytes_low[i*8 +: 8];
    for (i = 0; i < 7; i++) win[8+i] = w.bytes_high[i*8 +: 8];

    // skip legacy prefixes, and REX bytes in long mode
    while (scanning && p < xild_pkg::WIN_LIMIT) begin
      b = win[p];
      if (op_in(b, LEGACY_PREFIXES, 10)) begin
        p++;
      end else if (long_mode && b >= REX_LO && b <= REX_HI) begin
        rex = 1'b1;
        p++;
      end else begin
        scanning = 1'b0;
      end
    end

    if (p >= xild_pkg::WIN_LIMIT) begin
      status = xild_pkg::ST_WINDOW;
    end else begin
      op = win[p];
      p++;
      if (op_in(op, SINGLE_OPS, 5) || (op >= OP_PUSH_LO && op <= OP_POP_HI))
        len = p;
      else if (op_in(op, IMM8_OPS, 3) || (op >= OP_JCC8_LO && op <= OP_JCC8_HI) ||
               (op >= OP_MOV_R8_LO && op <= OP_MOV_R8_HI))
        len = p + 1;
      else if (op_in(op, IMM32_OPS, 3))
        len = p + 4;
      else if (op >= OP_MOV_R_LO && op <= OP_MOV_R_HI)
        len = p + (rex ? 8 : 4);
      else if (op == OP_RET_IMM16)
        len = p + 2;
      else if (op_in(op, MODRM_IMM8_OPS, 4))
        len = modrm_span(p, 1);
      else if (op_in(op, MODRM_IMM32_OPS, 2))
        len = modrm_span(p, 4);
      else if (op_in(op, MODRM_ONLY_OPS, 23))
        len = modrm_span(p, 0);
      else if (op == OP_ESC) begin
        if (p >= xild_pkg::WIN_LIMIT) begin
          win_err = 1'b1;
        end else begin
          op2 = win[p];
          p++;
          if (op2 >= OP2_JCC_LO && op2 <= OP2_JCC_HI)
            len = p + 4;
          else if ((op2 >= OP2_CMOV_LO && op2 <= OP2_CMOV_HI) ||
                   op_in(op2, TWO_BYTE_MODRM_OPS, 18))
            len = modrm_span(p, 0);
        end
      end
      if (win_err) status = xild_pkg::ST_WINDOW;
      else if (len == 0) status = xild_pkg::ST_UNKNOWN;
      else if (len > xild_pkg::WIN_LIMIT) status = xild_pkg::ST_WINDOW;
    end

    if (status != xild_pkg::ST_OK) len = 0;
    res.insn_length = len[3:0];
    res.status = status;
    return res;
  endfunction

  function void note_window(xild_pkg::in_word_t w);
    pending_lengths.push_back(predict_length(w));
  endfunction

  function void check_result(xild_pkg::out_word_t got);
    xild_pkg::out_word_t exp;
    if (pending_lengths.size() == 0) begin
      $display("%0t: result with nothing pending: len %0d status %0d",
               $time, got.insn_length, got.status);
      errors++;
      return;
    end
    exp = pending_lengths.pop_front();
    if (got.insn_length !== exp.insn_length) begin
      $display("%0t: insn_length mismatch: expected %0d, actual %0d",
               $time, exp.insn_length, got.insn_length);
      errors++;
    end
    if (got.status !== exp.status) begin
      $display("%0t: status mismatch: expected %0d, actual %0d",
               $time, exp.status, got.status);
      errors++;
    end
  endfunction
endclass

module tb_x86_instruction_length_decoder;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  xild_pkg::in_word_t  in_data = '0;
  logic                cfg_wr_en = 1'b0;
  logic                cfg_wr_data = 1'b0;
  logic                out_valid;
  xild_pkg::out_word_t out_data;

  length_scoreboard sb = new;
  bit burst = 1'b0;
  int guard;
  int phase;

  x86_instruction_length_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run of about 1.5k words
  initial begin
    #2_000_000;
    $display("tb_x86_instruction_length_decoder failed");
    $finish;
  end

  // Sample at the edge, before the block's own updates land: a word moves when
  // start is high and busy low; a result counts whenever out_valid is high.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_window(in_data);
      if (out_valid) sb.check_result(out_data);
    end
  end

  // Place npfx copies of pfx, then the first n bytes of seq (first byte in the
  // top byte of those n), and fill the rest of the window at random.
  function automatic xild_pkg::in_word_t compose_window(int npfx, logic [7:0] pfx,
                                                        logic [119:0] seq, int n);
    logic [119:0] bits;
    xild_pkg::in_word_t w;
    int i;
    bits[31:0]   = $urandom;
    bits[63:32]  = $urandom;
    bits[95:64]  = $urandom;
    bits[119:96] = 24'($urandom);
    for (i = 0; i < npfx && i < 15; i++) bits[i*8 +: 8] = pfx;
    for (i = 0; i < n && npfx + i < 15; i++)
      bits[(npfx+i)*8 +: 8] = seq[(n-1-i)*8 +: 8];
    w = bits;
    return w;
  endfunction

  // Mostly a short prefix run and a decodable opcode with random operand
  // bytes; sometimes a long prefix run to hit the window edge, sometimes noise.
  function automatic xild_pkg::in_word_t random_window();
    logic [119:0] bits;
    logic [7:0] op;
    xild_pkg::in_word_t w;
    int p, npfx;
    bits[31:0]   = $urandom;
    bits[63:32]  = $urandom;
    bits[95:64]  = $urandom;
    bits[119:96] = 24'($urandom);
    if ($urandom_range(0, 9) != 0) begin
      npfx = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 15) : $urandom_range(0, 3);
      for (p = 0; p < npfx; p++)
        bits[p*8 +: 8] = ($urandom_range(0, 2) == 0) ? 8'(REX_LO + $urandom_range(0, 15))
                                                     : LEGACY_PREFIXES[$urandom_range(0, 9)*8 +: 8];
      if (p < 15) begin
        case ($urandom_range(0, 13))
          0:  op = SINGLE_OPS[$urandom_range(0, 4)*8 +: 8];
          1:  op = 8'(OP_PUSH_LO + $urandom_range(0, 15));
          2:  op = IMM8_OPS[$urandom_range(0, 2)*8 +: 8];
          3:  op = 8'(OP_JCC8_LO + $urandom_range(0, 15));
          4:  op = 8'(OP_MOV_R8_LO + $urandom_range(0, 7));
          5:  op = IMM32_OPS[$urandom_range(0, 2)*8 +: 8];
          6:  op = 8'(OP_MOV_R_LO + $urandom_range(0, 7));
          7:  op = OP_RET_IMM16;
          8:  op = MODRM_IMM8_OPS[$urandom_range(0, 3)*8 +: 8];
          9:  op = MODRM_IMM32_OPS[$urandom_range(0, 1)*8 +: 8];
          10: op = MODRM_ONLY_OPS[$urandom_range(0, 22)*8 +: 8];
          11, 12: op = OP_ESC;
          default: op = 8'($urandom);
        endcase
        bits[p*8 +: 8] = op;
        if (op == OP_ESC && p < 14) begin
          case ($urandom_range(0, 3))
            0: bits[(p+1)*8 +: 8] = 8'(OP2_JCC_LO + $urandom_range(0, 15));
            1: bits[(p+1)*8 +: 8] = 8'(OP2_CMOV_LO + $urandom_range(0, 15));
            2: bits[(p+1)*8 +: 8] = TWO_BYTE_MODRM_OPS[$urandom_range(0, 17)*8 +: 8];
            default: bits[(p+1)*8 +: 8] = 8'($urandom);
          endcase
        end
      end
    end
    w = bits;
    return w;
  endfunction

  // Hold start low for a random gap (none while in a burst), then present the
  // word and advance once the block takes it. Called and returns at an edge.
  task automatic send_word(input xild_pkg::in_word_t w);
    int gap;
    if ($urandom_range(0, 39) == 0) burst = !burst;
    gap = burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
  endtask

  // Drain the pipeline, then write long_mode and switch the predictor with it.
  task automatic write_mode(input bit mode);
    start <= 1'b0;
    while (sb.pending_lengths.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.long_mode = mode;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words, long mode out of reset
    send_word('0);                                               // unlisted opcode
    send_word('1);                                               // all ones, ModR/M reg form
    send_word(compose_window(0, PFX_OPSIZE, OP_NOP, 1));
    send_word(compose_window(15, PFX_OPSIZE, '0, 0));            // prefixes fill window
    send_word(compose_window(14, PFX_REP, OP_ESC, 1));           // escape is last byte
    send_word(compose_window(14, PFX_ADDRSIZE, OP_NOP, 1));      // longest legal length
    send_word(compose_window(0, PFX_OPSIZE, {REX_W, OP_MOV_R_LO}, 2));  // imm64
    send_word(compose_window(0, PFX_OPSIZE, {OP_MOV_STORE, 8'h04, 8'h25}, 3));  // SIB, no base
    send_word(compose_window(0, PFX_OPSIZE, {OP_MOV_LOAD, 8'h05}, 2));          // disp32 / RIP
    send_word(compose_window(0, PFX_OPSIZE, {OP_GRP1_IMM32, 8'h84, 8'h24}, 3));
    send_word(compose_window(0, PFX_OPSIZE, {OP_GRP1_IMM32, 8'h04, 8'h05}, 3));
    send_word(compose_window(0, PFX_OPSIZE, {OP_GRP1_IMM8, 8'h44, 8'h24}, 3));
    send_word(compose_window(0, PFX_OPSIZE, {OP_ESC, OP2_JCC_LO}, 2));
    send_word(compose_window(0, PFX_OPSIZE, {OP_ESC, OP2_MOVZX, 8'h45}, 3));
    send_word(compose_window(0, PFX_OPSIZE, {OP_ESC, OP2_CMOVL, 8'hC0}, 3));
    send_word(compose_window(0, PFX_OPSIZE, {OP_ESC, OP2_UD2}, 2));   // unknown two-byte
    send_word(compose_window(12, PFX_OPSIZE, {OP_MOV_IMM32, 8'h80}, 2));  // runs past window
    send_word(compose_window(13, PFX_REP, {OP_ESC, OP2_JCC_LO}, 2));      // rel32 past window
    send_word(compose_window(0, PFX_OPSIZE, OP_RET_IMM16, 1));
    send_word(compose_window(3, REX_W, OP_INT, 1));
    send_word(compose_window(0, PFX_OPSIZE, OP_CALL, 1));
    send_word(compose_window(0, PFX_OPSIZE, OP_PUSH_LO, 1));
    send_word(compose_window(0, PFX_OPSIZE, OP_UNLISTED, 1));

    // 32-bit mode: REX bytes turn into unknown opcodes
    write_mode(1'b0);
    send_word(compose_window(0, PFX_OPSIZE, {REX_W, OP_MOV_R_LO}, 2));
    send_word(compose_window(0, PFX_OPSIZE, OP_MOV_R_LO, 1));

    // Random words, alternating the mode between phases
    for (phase = 0; phase < 4; phase++) begin
      if (phase > 0) write_mode(phase[0] ? 1'b1 : 1'b0);
      repeat (375) send_word(random_window());
    end
    start <= 1'b0;

    // Drain, then keep watching for stray results
    for (guard = 0; guard < 1000 && sb.pending_lengths.size() != 0; guard++)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (sb.pending_lengths.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending_lengths.size());
      sb.errors++;
    end

    if (sb.errors == 0) begin
      $display("tb_x86_instruction_length_decoder passed");
    end else begin
      $display("tb_x86_instruction_length_decoder failed");
    end
    $finish;
  end

endmodule

>>> x86_instruction_length_decoder.f
rtl/core/xild_pkg.sv
rtl/core/xild_classify.sv
rtl/core/xild_locate.sv
rtl/core/xild_decode.sv
rtl/core/x86_instruction_length_decoder.sv
dv/tb_x86_instruction_length_decoder.sv
